// ----- hdl/int32_stack_machine_alu_core_assert.svh -----
// ---------------------------------------------------------------------------
// int32_stack_machine_alu_core_assert.svh
// assertion macros for the stack machine core
// ---------------------------------------------------------------------------
`ifndef INT32_STACK_MACHINE_ALU_CORE_ASSERT_SVH
`define INT32_STACK_MACHINE_ALU_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stack machine check failed: same-cycle implication");

// next-cycle implication
`define SM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stack machine check failed: next-cycle implication");

`else

`define SM_ASSERT_IMP(label, clk, rst, ante, cons)
`define SM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/i32sm_pkg.sv -----
// ---------------------------------------------------------------------------
// i32sm_pkg
// shared constants for the 32-bit stack machine core
// ---------------------------------------------------------------------------
package i32sm_pkg;

   localparam int DATA_W        = 32;
   localparam int STEP_W        = $clog2(DATA_W);
   localparam int DEPTH_OUT_W   = 7;
   localparam int STACK_DEPTH_DEF = 64;

   // opcodes
   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;
   localparam logic [1:0] ST_DIVZ  = 2'd3;

   typedef logic [DATA_W-1:0] word_type;

endpackage

// ----- hdl/int32_stack_machine_alu_core.sv -----
// timing: push, add, sub, mul and every flagged case give their result from the execute
// state; divide runs bit-serially, one quotient bit per cycle, then the finish state commits
// flow: a new request is taken only in the idle state, so each word, divide included, is
// finished before the next is accepted; a stalled response holds the core in the done state
// reset: synchronous, active high; the stack comes up empty
// ---------------------------------------------------------------------------
// int32_stack_machine_alu_core
// 32-bit integer stack machine: push, add, sub, mul, signed divide. top of
// stack lives in a register, the entries below it in a synchronous memory.
// ---------------------------------------------------------------------------
`include "int32_stack_machine_alu_core_assert.svh"

module int32_stack_machine_alu_core
   import i32sm_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] immediate
   input  logic [2:0]  req_tuser,   // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [31:0] top_value, [38:32] stack_depth, [40:39] status
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   word_type             mem [STACK_DEPTH];

   logic [2:0]           state_ff, state_in;
   logic [2:0]           op_ff;
   word_type             imm_ff;
   word_type             rd_ff;
   word_type             tos_ff, tos_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [1:0]           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [47:0]          rsp_data_ff;

   word_type             rem_ff, quo_ff, dvs_ff;
   logic                 neg_ff;
   logic [STEP_W-1:0]    step_ff;

   logic                 accept, out_free, commit, emit, wr_en, div_start;
   logic [CNT_W-1:0]     count_m1, count_m2;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   word_type             a_mag, b_mag, q_fix, top_out;
   logic [DATA_W:0]      div_sh, div_diff;
   logic [CNT_W+DEPTH_OUT_W-1:0] count_wide;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign count_m1 = count_ff - CNT_W'(1);
   assign count_m2 = count_ff - CNT_W'(2);
   assign rd_addr  = count_m2[ADDR_W-1:0];
   assign wr_addr  = count_m1[ADDR_W-1:0];

   assign a_mag    = rd_ff[DATA_W-1]  ? (word_type'(0) - rd_ff)  : rd_ff;
   assign b_mag    = tos_ff[DATA_W-1] ? (word_type'(0) - tos_ff) : tos_ff;
   assign div_sh   = {rem_ff, quo_ff[DATA_W-1]};
   assign div_diff = div_sh - {1'b0, dvs_ff};
   assign q_fix    = neg_ff ? (word_type'(0) - quo_ff) : quo_ff;

   always_comb begin
      state_in  = state_ff;
      tos_in    = tos_ff;
      count_in  = count_ff;
      status_in = status_ff;
      commit    = 1'b0;
      emit      = 1'b0;
      wr_en     = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            commit    = 1'b1;
            status_in = ST_OK;
            case (op_ff)
               OP_PUSH: begin
                  if (count_ff == CNT_W'(STACK_DEPTH)) begin
                     status_in = ST_OVER;
                  end else begin
                     tos_in   = imm_ff;
                     count_in = count_ff + CNT_W'(1);
                     wr_en    = (count_ff != '0);
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (count_ff < CNT_W'(2)) begin
                     status_in = ST_UNDER;
                  end else begin
                     case (op_ff)
                        OP_ADD: begin
                           tos_in   = rd_ff + tos_ff;
                           count_in = count_m1;
                        end
                        OP_SUB: begin
                           tos_in   = rd_ff - tos_ff;
                           count_in = count_m1;
                        end
                        OP_MUL: begin
                           tos_in   = rd_ff * tos_ff;
                           count_in = count_m1;
                        end
                        default: begin
                           if (tos_ff == '0) begin
                              status_in = ST_DIVZ;
                           end else begin
                              commit    = 1'b0;
                              div_start = 1'b1;
                              state_in  = S_DIV;
                           end
                        end
                     endcase
                  end
               end
               default: begin
               end
            endcase
         end
         S_DIV: begin
            if (step_ff == STEP_W'(DATA_W - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            commit    = 1'b1;
            tos_in    = q_fix;
            count_in  = count_m1;
            status_in = ST_OK;
         end
         S_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (commit) begin
         if (out_free) begin
            emit     = 1'b1;
            state_in = S_IDLE;
         end else begin
            state_in = S_DONE;
         end
      end
   end

   assign count_wide   = {{DEPTH_OUT_W{1'b0}}, count_in};
   assign top_out      = (count_in != '0) ? tos_in : '0;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      if (accept) begin
         op_ff  <= req_tuser;
         imm_ff <= req_tdata;
      end
      if (emit) begin
         rsp_data_ff <= {7'd0, status_in, count_wide[DEPTH_OUT_W-1:0], top_out};
      end
   end

   // stack memory, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= tos_ff;
      end
      if (accept) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // restoring divider on magnitudes
   always_ff @(posedge clock) begin
      if (div_start) begin
         rem_ff  <= '0;
         quo_ff  <= a_mag;
         dvs_ff  <= b_mag;
         neg_ff  <= rd_ff[DATA_W-1] ^ tos_ff[DATA_W-1];
         step_ff <= '0;
      end else if (state_ff == S_DIV) begin
         step_ff <= step_ff + STEP_W'(1);
         rem_ff  <= div_diff[DATA_W] ? div_sh[DATA_W-1:0] : div_diff[DATA_W-1:0];
         quo_ff  <= {quo_ff[DATA_W-2:0], !div_diff[DATA_W]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SM_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(STACK_DEPTH))
   `SM_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == S_EXEC)
   `SM_ASSERT_IMP(a_div_nonzero, clock, reset, state_ff == S_DIV, dvs_ff != '0)
   `SM_ASSERT_NEXT(a_count_step, clock, reset, 1'b1,
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1)) ||
      (count_ff == $past(count_ff) - CNT_W'(1)))

endmodule
